@@ sv/pedal_sensor_plausibility_assert.svh @@
// assertion macros for the pedal sensor plausibility block
// no dependencies; included by the port checker
`ifndef PEDAL_SENSOR_PLAUSIBILITY_ASSERT_SVH
`define PEDAL_SENSOR_PLAUSIBILITY_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define PSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define PSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/psp_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers of the pedal sensor plausibility block
// no dependencies
package psp_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int PCT_BITS      = 7;
    localparam int TOL_BITS      = 7;
    localparam int NUM_BITS      = SAMPLE_BITS + PCT_BITS;
    localparam int N_PEDAL       = 3;
    localparam int CH_BITS       = 2;
    localparam int STEP_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int FULL_SCALE    = 100;
    localparam int THROTTLE_TRIP = 5;
    localparam int BRAKE_TRIP    = 25;

    localparam int ACCEL1_MIN_RST = 496;
    localparam int ACCEL1_MAX_RST = 1365;
    localparam int ACCEL2_MIN_RST = 992;
    localparam int ACCEL2_MAX_RST = 2916;
    localparam int BRAKE_MIN_RST  = 2500;
    localparam int BRAKE_MAX_RST  = 3536;
    localparam int TOL_RST        = 10;

    // pedal channel slots
    localparam int CH_ACCEL1 = 0;
    localparam int CH_ACCEL2 = 1;
    localparam int CH_BRAKE  = 2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [PCT_BITS-1:0]    t_pct;
    typedef logic [TOL_BITS-1:0]    t_tol;
    typedef logic [NUM_BITS-1:0]    t_num;

    typedef struct packed {
        t_sample accel1_sample;
        t_sample accel2_sample;
        t_sample brake_sample;
        t_sample circuit_sample;
    } t_in_word;

    typedef struct packed {
        t_pct    accel1_percent;
        t_pct    accel2_percent;
        t_pct    brake_percent;
        t_sample circuit_level;
        logic    accel_agree;
        logic    brake_accel_ok;
    } t_out_word;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACCEL1_MIN,
        CFG_ACCEL1_MAX,
        CFG_ACCEL2_MIN,
        CFG_ACCEL2_MAX,
        CFG_BRAKE_MIN,
        CFG_BRAKE_MAX,
        CFG_TOLERANCE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV,
        ST_FINISH
    } t_state;

    // floor((old + new) / 2) without losing the carry
    function automatic t_sample fold(t_sample old_lvl, t_sample smp);
        logic [SAMPLE_BITS:0] sum;
        sum = {1'b0, old_lvl} + {1'b0, smp};
        return sum[SAMPLE_BITS:1];
    endfunction

endpackage

@@ sv/pedal_sensor_plausibility.sv @@
`timescale 1ns / 1ps
// top level of the pedal sensor plausibility block: sequencer, shared divider, config
// depends on psp_pkg
//
// Each accepted word carries one filtered sample for both accelerator sensors, the
// brake sensor and the shutdown-circuit sense. The samples are averaged into running
// levels, the three pedal levels are clamped to their configured range and kept, and
// each is scaled to 0..100 percent (truncated) by one restoring divider that the
// sequencer shares between the pedals, one quotient bit per cycle. After the accept
// edge, each pedal takes one clamp/scale step and then its divider steps, and a final
// step builds the result; the block takes no new word before that step is done. A
// pedal whose min is at or above its max skips the divider (percent 0 when equal,
// 100 when above). The result sits in an output register; the block keeps accepting
// while it waits there, and only the final cycle of the next word holds until that
// register is free.
// Configuration writes are taken at any time on the plain write port and are meant
// to be made while the block is idle; an index beyond the tolerance register is
// ignored.
module pedal_sensor_plausibility
    import psp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample words
    input  logic                    i_in_valid,
    input  t_in_word                i_in_word,
    output logic                    o_in_stall,
    // result words
    output logic                    o_out_valid,
    output t_out_word               o_out_word,
    input  logic                    i_out_stall,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data
);

    // configuration registers, pedal ranges indexed by channel slot
    t_sample r_cfg_min [N_PEDAL];
    t_sample r_cfg_max [N_PEDAL];
    t_tol    r_tol;

    // running state
    t_sample r_lvl [N_PEDAL], n_lvl [N_PEDAL];
    t_sample r_circ, n_circ;
    logic    r_latch, n_latch;

    // sequencer
    t_state               r_state, n_state;
    logic [CH_BITS-1:0]   r_ch, n_ch;
    logic [STEP_BITS-1:0] r_step, n_step;

    // shared divider: remainder, shifted divisor, quotient so far
    t_num r_rem, n_rem;
    t_num r_den, n_den;
    t_pct r_quo, n_quo;
    t_pct r_pct [N_PEDAL], n_pct [N_PEDAL];

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    logic in_acc;
    logic out_free;

    // clamp and scale of the current pedal
    t_sample cur_lo, cur_hi, cur_lvl;
    t_sample lo_clamped, clamped, span, offset;
    t_num    scaled;
    logic    last_ch;

    // divider step
    logic    fits;
    t_num    trial;

    // result assembly
    t_pct    pct_diff;
    logic    agree;
    logic    latch_next;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // lower clamp first, then upper, so a reversed range lands on max
    assign cur_lo     = r_cfg_min[r_ch];
    assign cur_hi     = r_cfg_max[r_ch];
    assign cur_lvl    = r_lvl[r_ch];
    assign lo_clamped = (cur_lvl < cur_lo) ? cur_lo : cur_lvl;
    assign clamped    = (lo_clamped > cur_hi) ? cur_hi : lo_clamped;
    assign span       = cur_hi - cur_lo;
    assign offset     = clamped - cur_lo;
    // offset * 100 as 64 + 32 + 4
    assign scaled     = (NUM_BITS'(offset) << 6) + (NUM_BITS'(offset) << 5)
                      + (NUM_BITS'(offset) << 2);
    assign last_ch    = (r_ch == CH_BITS'(N_PEDAL - 1));

    // one restoring step per cycle
    assign fits  = (r_rem >= r_den);
    assign trial = r_rem - r_den;

    // agreement and brake-plus-throttle latch on the finished percentages
    assign pct_diff = (r_pct[CH_ACCEL1] > r_pct[CH_ACCEL2])
                    ? (r_pct[CH_ACCEL1] - r_pct[CH_ACCEL2])
                    : (r_pct[CH_ACCEL2] - r_pct[CH_ACCEL1]);
    assign agree    = (pct_diff <= r_tol);

    always_comb begin
        priority if ((r_pct[CH_ACCEL1] > PCT_BITS'(THROTTLE_TRIP))
                     && (r_pct[CH_BRAKE] > PCT_BITS'(BRAKE_TRIP))) begin
            latch_next = 1'b0;
        end else if (r_pct[CH_BRAKE] == '0) begin
            latch_next = 1'b1;
        end else begin
            latch_next = r_latch;
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_step      = r_step;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_pct       = r_pct;
        n_lvl       = r_lvl;
        n_circ      = r_circ;
        n_latch     = r_latch;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_lvl[CH_ACCEL1] = fold(r_lvl[CH_ACCEL1], i_in_word.accel1_sample);
                    n_lvl[CH_ACCEL2] = fold(r_lvl[CH_ACCEL2], i_in_word.accel2_sample);
                    n_lvl[CH_BRAKE]  = fold(r_lvl[CH_BRAKE], i_in_word.brake_sample);
                    n_circ           = fold(r_circ, i_in_word.circuit_sample);
                    n_ch             = CH_BITS'(CH_ACCEL1);
                    n_state          = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                n_lvl[r_ch] = clamped;
                if (cur_lo >= cur_hi) begin
                    // empty or reversed range: no division
                    n_pct[r_ch] = (cur_lo == cur_hi) ? '0 : PCT_BITS'(FULL_SCALE);
                    if (last_ch) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end else begin
                    n_rem   = scaled;
                    n_den   = NUM_BITS'(span) << (PCT_BITS - 1);
                    n_quo   = '0;
                    n_step  = STEP_BITS'(PCT_BITS - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo = {r_quo[PCT_BITS-2:0], fits};
                n_rem = fits ? trial : r_rem;
                n_den = r_den >> 1;
                if (r_step == '0) begin
                    n_pct[r_ch] = {r_quo[PCT_BITS-2:0], fits};
                    if (last_ch) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_CLAMP;
                    end
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_latch                   = latch_next;
                    n_out_word.accel1_percent = r_pct[CH_ACCEL1];
                    n_out_word.accel2_percent = r_pct[CH_ACCEL2];
                    n_out_word.brake_percent  = r_pct[CH_BRAKE];
                    n_out_word.circuit_level  = r_circ;
                    n_out_word.accel_agree    = agree;
                    n_out_word.brake_accel_ok = latch_next;
                    n_out_valid               = 1'b1;
                    n_state                   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control, running state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_lvl       <= '{default: '0};
            r_circ      <= '0;
            r_latch     <= 1'b1;
            r_cfg_min[CH_ACCEL1] <= SAMPLE_BITS'(ACCEL1_MIN_RST);
            r_cfg_max[CH_ACCEL1] <= SAMPLE_BITS'(ACCEL1_MAX_RST);
            r_cfg_min[CH_ACCEL2] <= SAMPLE_BITS'(ACCEL2_MIN_RST);
            r_cfg_max[CH_ACCEL2] <= SAMPLE_BITS'(ACCEL2_MAX_RST);
            r_cfg_min[CH_BRAKE]  <= SAMPLE_BITS'(BRAKE_MIN_RST);
            r_cfg_max[CH_BRAKE]  <= SAMPLE_BITS'(BRAKE_MAX_RST);
            r_tol                <= TOL_BITS'(TOL_RST);
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            r_lvl       <= n_lvl;
            r_circ      <= n_circ;
            r_latch     <= n_latch;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACCEL1_MIN: r_cfg_min[CH_ACCEL1] <= i_cfg_data;
                    CFG_ACCEL1_MAX: r_cfg_max[CH_ACCEL1] <= i_cfg_data;
                    CFG_ACCEL2_MIN: r_cfg_min[CH_ACCEL2] <= i_cfg_data;
                    CFG_ACCEL2_MAX: r_cfg_max[CH_ACCEL2] <= i_cfg_data;
                    CFG_BRAKE_MIN:  r_cfg_min[CH_BRAKE]  <= i_cfg_data;
                    CFG_BRAKE_MAX:  r_cfg_max[CH_BRAKE]  <= i_cfg_data;
                    CFG_TOLERANCE:  r_tol <= i_cfg_data[TOL_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_pct      <= n_pct;
        r_out_word <= n_out_word;
    end

endmodule

@@ sv/psp_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the pedal sensor plausibility block, bound to the top level
// depends on psp_pkg and pedal_sensor_plausibility_assert.svh
`include "pedal_sensor_plausibility_assert.svh"

module psp_checker
    import psp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_stall,
    input  logic                    o_out_valid,
    input  t_out_word               o_out_word,
    input  logic                    i_out_stall
);

    logic in_acc;
    logic out_held;
    logic rearm_due;
    logic trip_due;
    logic latch_ok;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign rearm_due = o_out_valid && (o_out_word.brake_percent == '0);
    assign trip_due  = o_out_valid
                     && (o_out_word.accel1_percent > PCT_BITS'(THROTTLE_TRIP))
                     && (o_out_word.brake_percent > PCT_BITS'(BRAKE_TRIP));
    assign latch_ok  = o_out_word.brake_accel_ok;

    // a held result word stays offered
    `PSP_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, out_held, o_out_valid, "stalled result dropped")

    // a held result word does not move
    `PSP_ASSERT_NEXT(a_word_hold, i_clk, i_rst_n, out_held, $stable(o_out_word), "stalled word moved")

    // a taken word keeps the block busy for its work
    `PSP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "busy flag missing")

    // brake released re-arms the latch
    `PSP_ASSERT_IMPLY(a_latch_rearm, i_clk, i_rst_n, rearm_due, latch_ok, "latch not re-armed")

    // throttle and brake together trip the latch
    `PSP_ASSERT_IMPLY(a_latch_trip, i_clk, i_rst_n, trip_due, !latch_ok, "latch not tripped")

endmodule

bind pedal_sensor_plausibility psp_checker u_psp_checker (.*);
